// ===== hdl/mrf_pkg.sv =====
`timescale 1ns / 1ps

package mrf_pkg;

   // fixed field widths of the transactions
   localparam int VALUE_W = 12;
   localparam int OUT_W   = 11;

   // per-value occurrence count, saturating
   localparam int          COUNT_W   = 2;
   localparam logic [1:0]  COUNT_ZERO = 2'd0;
   localparam logic [1:0]  COUNT_TWO  = 2'd2;
   localparam logic [1:0]  COUNT_SAT  = 2'd3;

   localparam int DEFAULT_MAX_SET_SIZE = 1024;

   // sequencer states, one-hot
   typedef enum logic [4:0] {
      ST_CLEAR  = 5'b00001,
      ST_IDLE   = 5'b00010,
      ST_UPDATE = 5'b00100,
      ST_SCAN   = 5'b01000,
      ST_DONE   = 5'b10000
   } state_type;

endpackage

// ===== hdl/mrf_req_if.sv =====
`timescale 1ns / 1ps

interface mrf_req_if
   import mrf_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] value;
   logic               last;

   modport source (output valid, output value, output last, input ready);
   modport sink   (input valid, input value, input last, output ready);
endinterface

// ===== hdl/mrf_rsp_if.sv =====
`timescale 1ns / 1ps

interface mrf_rsp_if
   import mrf_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [OUT_W-1:0] repeated_value;
   logic [OUT_W-1:0] missing_value;
   logic             repeated_found;
   logic             missing_found;
   logic             input_error;

   modport source (output valid, output repeated_value, output missing_value,
                   output repeated_found, output missing_found, output input_error,
                   input ready);
   modport sink   (input valid, input repeated_value, input missing_value,
                   input repeated_found, input missing_found, input input_error,
                   output ready);
endinterface

// ===== hdl/mrf_ram.sv =====
`timescale 1ns / 1ps

module mrf_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/missing_and_repeated_finder_top.sv =====
`timescale 1ns / 1ps

// Finds the repeated and the missing value of a set that should hold 1..n, one
// value per request transaction, with last set on the final one (n is the number
// of transactions). Each request is handled as a read and a write-back of a
// 2-bit saturating count in a single-port-write count RAM. On the last request a
// sequencer sweeps the RAM one entry per cycle, reporting the highest value
// counted exactly twice and the highest value never seen while zeroing each
// entry; the sweep covers max(n, highest value counted) entries. Out-of-range
// values and overlong sets raise input_error and are not counted. After reset
// the RAM is cleared before the first request is taken. A finished response
// sits in an output register, so the next set can be loaded while it waits.
module missing_and_repeated_finder_top
   import mrf_pkg::*;
#(
   parameter int MAX_SET_SIZE = DEFAULT_MAX_SET_SIZE
) (
   input  logic      clock,
   input  logic      reset,
   mrf_req_if.sink   req_ch,
   mrf_rsp_if.source rsp_ch
);

   localparam int AW = $clog2(MAX_SET_SIZE);
   localparam int CW = $clog2(MAX_SET_SIZE + 1);
   localparam int LW = (VALUE_W > CW) ? VALUE_W : CW;

   state_type state_ff, state_in;

   logic [CW-1:0] item_count_ff;
   logic          error_ff;
   logic [CW-1:0] hwm_ff;
   logic [AW-1:0] addr_ff;
   logic          upd_we_ff;
   logic          last_ff;

   logic [CW-1:0] idx_ff;
   logic [CW-1:0] limit_ff;
   logic [CW-1:0] n_ff;
   logic          p_valid_ff;
   logic [AW-1:0] p_addr_ff;

   logic [CW-1:0] rep_ff;
   logic [CW-1:0] mis_ff;
   logic          rep_found_ff;
   logic          mis_found_ff;
   logic          err_res_ff;

   logic             rsp_valid_ff;
   logic [OUT_W-1:0] out_rep_ff;
   logic [OUT_W-1:0] out_mis_ff;
   logic             out_rep_found_ff;
   logic             out_mis_found_ff;
   logic             out_err_ff;

   logic               accept;
   logic [LW-1:0]      val_ext;
   logic               in_range;
   logic               set_full;
   logic [AW-1:0]      req_addr;
   logic [CW-1:0]      req_val;
   logic               sweeping;
   logic               issue;
   logic [CW-1:0]      p_val;
   logic               p_in_set;
   logic               rsp_free;
   logic [CW-1:0]      sweep_limit;

   logic               ram_we;
   logic [AW-1:0]      ram_wa;
   logic [COUNT_W-1:0] ram_wd;
   logic [AW-1:0]      ram_ra;
   logic [COUNT_W-1:0] ram_rd;

   // request decode
   assign accept   = req_ch.valid && req_ch.ready;
   assign val_ext  = LW'(req_ch.value);
   assign in_range = (req_ch.value != '0) && (val_ext <= LW'(MAX_SET_SIZE));
   assign set_full = (item_count_ff == CW'(MAX_SET_SIZE));
   assign req_addr = AW'(val_ext - LW'(1));
   assign req_val  = CW'(val_ext);

   assign req_ch.ready = (state_ff == ST_IDLE);

   // sweep pipeline: read at idx, write back zero in the next cycle
   assign sweeping    = (state_ff == ST_SCAN) || (state_ff == ST_CLEAR);
   assign issue       = sweeping && (idx_ff != limit_ff);
   assign p_val       = CW'(p_addr_ff) + CW'(1);
   assign p_in_set    = (p_val <= n_ff);
   assign rsp_free    = !rsp_valid_ff || rsp_ch.ready;
   assign sweep_limit = (item_count_ff > hwm_ff) ? item_count_ff : hwm_ff;

   // count ram port control: saturating increment or sweep clear
   always_comb begin
      ram_ra = sweeping ? idx_ff[AW-1:0] : req_addr;
      ram_we = 1'b0;
      ram_wa = p_addr_ff;
      ram_wd = COUNT_ZERO;
      if (state_ff == ST_UPDATE) begin
         ram_we = upd_we_ff;
         ram_wa = addr_ff;
         ram_wd = (ram_rd == COUNT_SAT) ? ram_rd : ram_rd + COUNT_W'(1);
      end else if (sweeping) begin
         ram_we = p_valid_ff;
      end
   end

   mrf_ram #(
      .WIDTH (COUNT_W),
      .DEPTH (MAX_SET_SIZE)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (!issue && !p_valid_ff) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            state_in = last_ff ? ST_SCAN : ST_IDLE;
         end
         ST_SCAN: begin
            if (!issue && !p_valid_ff) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         item_count_ff <= '0;
         error_ff      <= 1'b0;
         hwm_ff        <= '0;
         idx_ff        <= '0;
         limit_ff      <= CW'(MAX_SET_SIZE);
         p_valid_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;

         // set bookkeeping on each request
         if (accept) begin
            if (set_full || !in_range) begin
               error_ff <= 1'b1;
            end
            if (!set_full) begin
               item_count_ff <= item_count_ff + CW'(1);
               if (in_range && (req_val > hwm_ff)) begin
                  hwm_ff <= req_val;
               end
            end
         end

         // start of sweep: latch bounds, reopen the set
         if (state_ff == ST_UPDATE && last_ff) begin
            idx_ff        <= '0;
            limit_ff      <= sweep_limit;
            item_count_ff <= '0;
            error_ff      <= 1'b0;
            hwm_ff        <= '0;
         end

         if (issue) begin
            idx_ff <= idx_ff + CW'(1);
         end
         p_valid_ff <= issue;

         // output register handshake
         if (state_ff == ST_DONE && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (accept) begin
         addr_ff   <= req_addr;
         upd_we_ff <= !set_full && in_range;
         last_ff   <= req_ch.last;
      end

      if (state_ff == ST_UPDATE && last_ff) begin
         n_ff         <= item_count_ff;
         err_res_ff   <= error_ff;
         rep_ff       <= '0;
         mis_ff       <= '0;
         rep_found_ff <= 1'b0;
         mis_found_ff <= 1'b0;
      end

      p_addr_ff <= idx_ff[AW-1:0];

      // compare stage: ascending sweep, so the latest hit is the highest
      if (state_ff == ST_SCAN && p_valid_ff && p_in_set) begin
         if (ram_rd == COUNT_TWO) begin
            rep_ff       <= p_val;
            rep_found_ff <= 1'b1;
         end
         if (ram_rd == COUNT_ZERO) begin
            mis_ff       <= p_val;
            mis_found_ff <= 1'b1;
         end
      end

      if (state_ff == ST_DONE && rsp_free) begin
         out_rep_ff       <= OUT_W'(rep_ff);
         out_mis_ff       <= OUT_W'(mis_ff);
         out_rep_found_ff <= rep_found_ff;
         out_mis_found_ff <= mis_found_ff;
         out_err_ff       <= err_res_ff;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.repeated_value = out_rep_ff;
   assign rsp_ch.missing_value  = out_mis_ff;
   assign rsp_ch.repeated_found = out_rep_found_ff;
   assign rsp_ch.missing_found  = out_mis_found_ff;
   assign rsp_ch.input_error    = out_err_ff;

endmodule
